// ===== rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Types and constants shared by the byte ring FIFO controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package brf_pkg;

    // Pointer width: one bit above the largest supported address (256 bytes).
    localparam int PTR_W  = 9;
    localparam int LANES  = 8;
    localparam int LANE_W = 3;
    localparam int ROWP_W = PTR_W - LANE_W;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    // Kind of result the datapath loads into its output register.
    localparam logic [1:0] RES_REFUSE = 2'd0;
    localparam logic [1:0] RES_PUT    = 2'd1;
    localparam logic [1:0] RES_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] data;
        logic [3:0]  length;
    } brf_in_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] read_bytes;
        logic [3:0]  byte_count;
        logic [8:0]  fill_level;
        logic        last;
    } brf_out_t;

    typedef struct packed {
        logic       latch;
        logic       put_commit;
        logic       load_out;
        logic [1:0] res_sel;
        logic       pop;
    } brf_ctl_t;

    typedef struct packed {
        logic is_put;
        logic is_get;
        logic is_drain;
        logic put_fits;
        logic get_fits;
        logic empty;
        logic drain_last;
    } brf_sts_t;

endpackage

// ===== rtl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/brf_dpath.sv =====
// ----------------------------------------------------------------------------
// brf_dpath
// Ring buffer datapath: pointers, eight byte-wide RAM banks, command holding
// register, byte rotation and the result register.
// ----------------------------------------------------------------------------
module brf_dpath #(
    parameter int DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  brf_pkg::brf_in_t  in_data,
    input  brf_pkg::brf_ctl_t ctl,
    output brf_pkg::brf_sts_t sts,
    output brf_pkg::brf_out_t out_data
);
    import brf_pkg::*;

    localparam int ROWS   = DEPTH / LANES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROWP_W-1:0] ROW_MASK = ROWP_W'(ROWS - 1);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] held;
    logic [PTR_W:0]   free_space;
    logic [3:0]       n_read;
    logic [63:0]      rd_packed;
    brf_in_t          item_reg;
    brf_out_t         out_reg, out_next;
    logic [7:0]       rd_byte [LANES];

    assign held       = wp_reg - rp_reg;
    assign free_space = (PTR_W+1)'(DEPTH) - {1'b0, held};

    assign sts.is_put     = (item_reg.cmd == CMD_PUT);
    assign sts.is_get     = (item_reg.cmd == CMD_GET);
    assign sts.is_drain   = (item_reg.cmd == CMD_DRAIN);
    assign sts.put_fits   = (item_reg.length <= 4'd8)
                          && (free_space >= (PTR_W+1)'(item_reg.length));
    assign sts.get_fits   = (item_reg.length <= 4'd8)
                          && (PTR_W'(item_reg.length) <= held);
    assign sts.empty      = (held == '0);
    assign sts.drain_last = (held <= PTR_W'(8));

    // Each put or read touches every bank at most once. A lane below the
    // pointer's low bits belongs to the next row of the ring.
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic [LANE_W-1:0] w_idx;
        logic [ROWP_W-1:0] w_row, r_row;
        logic              w_en;

        assign w_idx = LANE_W'(b) - wp_reg[LANE_W-1:0];
        assign w_en  = ctl.put_commit && ({1'b0, w_idx} < item_reg.length);
        assign w_row = (wp_reg[PTR_W-1:LANE_W]
                       + ROWP_W'(LANE_W'(b) < wp_reg[LANE_W-1:0])) & ROW_MASK;
        assign r_row = (rp_reg[PTR_W-1:LANE_W]
                       + ROWP_W'(LANE_W'(b) < rp_reg[LANE_W-1:0])) & ROW_MASK;

        brf_ram #(
            .WIDTH(8),
            .DEPTH(ROWS)
        ) u_bank (
            .aclk (aclk),
            .we   (w_en),
            .waddr(ROW_AW'(w_row)),
            .wdata(item_reg.data[8*w_idx +: 8]),
            .raddr(ROW_AW'(r_row)),
            .rdata(rd_byte[b])
        );
    end

    assign n_read = sts.is_drain ? (sts.drain_last ? held[3:0] : 4'd8)
                                 : item_reg.length;

    always_comb begin
        logic [LANE_W-1:0] lane;
        rd_packed = '0;
        for (int i = 0; i < LANES; i++) begin
            lane = rp_reg[LANE_W-1:0] + LANE_W'(i);
            if (4'(i) < n_read) begin
                rd_packed[8*i +: 8] = rd_byte[lane];
            end
        end
    end

    always_comb begin
        out_next = '0;
        unique case (ctl.res_sel)
            RES_PUT: begin
                out_next.ok         = 1'b1;
                out_next.fill_level = held + PTR_W'(item_reg.length);
                out_next.last       = 1'b1;
            end
            RES_READ: begin
                out_next.ok         = 1'b1;
                out_next.read_bytes = rd_packed;
                out_next.byte_count = n_read;
                out_next.fill_level = sts.is_drain ? '0 : held - PTR_W'(item_reg.length);
                out_next.last       = sts.is_drain ? sts.drain_last : 1'b1;
            end
            default: begin
                out_next.fill_level = held;
                out_next.last       = 1'b1;
            end
        endcase
    end

    assign wp_next = ctl.put_commit ? wp_reg + PTR_W'(item_reg.length) : wp_reg;
    assign rp_next = ctl.pop ? rp_reg + PTR_W'(n_read) : rp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            item_reg <= in_data;
        end
        if (ctl.load_out) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/brf_ctrl.sv =====
// ----------------------------------------------------------------------------
// brf_ctrl
// Controller for the byte ring FIFO: sequences one command at a time and owns
// both handshakes.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  brf_pkg::brf_sts_t sts,
    output brf_pkg::brf_ctl_t ctl
);
    import brf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_CAP  = 2'd2;
    localparam logic [1:0] ST_RDW  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // The output register may be reloaded when empty or when its transfer
    // completes in this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_put) begin
                    if (out_free) begin
                        ctl.load_out   = 1'b1;
                        ctl.put_commit = sts.put_fits;
                        ctl.res_sel    = sts.put_fits ? RES_PUT : RES_REFUSE;
                        state_next     = ST_IDLE;
                    end
                end else if ((sts.is_get && sts.get_fits) || (sts.is_drain && !sts.empty)) begin
                    // The banks read at the read pointer during this cycle.
                    state_next = ST_CAP;
                end else if (out_free) begin
                    ctl.load_out = 1'b1;
                    ctl.res_sel  = RES_REFUSE;
                    state_next   = ST_IDLE;
                end
            end
            ST_CAP: begin
                if (out_free) begin
                    ctl.load_out = 1'b1;
                    ctl.res_sel  = RES_READ;
                    ctl.pop      = 1'b1;
                    state_next   = (sts.is_drain && !sts.drain_last) ? ST_RDW : ST_IDLE;
                end
            end
            ST_RDW: begin
                state_next = ST_CAP;
            end
        endcase
    end

    assign m_valid_next = ctl.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/byte_ring_fifo_burst.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst
// Byte FIFO on a power-of-two ring with all-or-nothing puts, gets and drains.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel carries one command (put up to eight
// bytes, get up to eight bytes, or drain everything held). Each command gives
// one result transfer on the m_ channel, except a drain of a non-empty ring,
// which gives one result per 8-byte chunk with last set on the final one.
// Commands are handled one at a time by the controller.
// A put or a refused command loads its result from the execute state; a get
// or the first drain chunk passes through the execute and capture states,
// because the byte banks have a registered read. Each further drain chunk
// takes one bank read state and one capture into the result register.
// A new command is taken only once the controller is idle again.
// Reset clears both pointers, so the ring is empty; the banks are not cleared.
// When the receiver stalls, the result register holds its value; the next
// command may still be taken and waits inside until the register is free.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst #(
    parameter int DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brf_pkg::brf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output brf_pkg::brf_out_t m_data
);
    import brf_pkg::*;

    brf_ctl_t ctl;
    brf_sts_t sts;

    brf_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .ctl    (ctl)
    );

    brf_dpath #(
        .DEPTH(DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .ctl     (ctl),
        .sts     (sts),
        .out_data(m_data)
    );

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.fill_level} <= 10'(DEPTH)))
        else $error("fill level above ring depth");

    a_refused_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ok) |-> (m_data.byte_count == 4'd0 && m_data.read_bytes == '0))
        else $error("refused result carries data");

    a_chunk_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |->
            (m_data.ok && m_data.byte_count == 4'd8 && m_data.fill_level == '0))
        else $error("non-final drain chunk is not a full chunk");
`endif

endmodule

// ===== dv/byte_ring_fifo_burst_tb.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_tb
// Self-checking bench for the byte ring FIFO. A queue of commands (directed
// corner cases, then random fill, get, drain and noise runs) feeds a clocked
// driver. A shadow ring predicts every result at the input transfer, and a
// clocked monitor compares each result transfer field by field.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int MAX_CHUNKS = 32;
    localparam int RANDOM_ITEMS = 140;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        brf_in_t     item;
        int unsigned gap;
    } pending_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    brf_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    brf_out_t m_data;

    byte_ring_fifo_burst #(
        .DEPTH(RING_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the ring.
    logic [7:0] shadow_ring [0:RING_DEPTH-1];
    logic [8:0] shadow_wr_ptr = '0;
    logic [8:0] shadow_rd_ptr = '0;

    brf_out_t    expected_results[$];
    pending_t    pending_q[$];
    pending_t    next_cmd;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    bit          ready_calm = 1'b0;
    bit          send_calm = 1'b0;
    int unsigned gen_fill = 0;
    int unsigned error_count = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned drains_seen = 0;
    int unsigned peak_fill = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned held_bytes();
        logic [8:0] diff;
        diff = shadow_wr_ptr - shadow_rd_ptr;
        return int'(diff);
    endfunction

    // Pops n bytes from the shadow ring, first byte in the low lane.
    function automatic logic [63:0] pop_shadow(int unsigned n);
        logic [63:0] word;
        int unsigned i;
        word = '0;
        for (i = 0; i < n; i++) begin
            word[8*i +: 8] = shadow_ring[shadow_rd_ptr[RING_AW-1:0]];
            shadow_rd_ptr = shadow_rd_ptr + 9'd1;
        end
        return word;
    endfunction

    task automatic predict_ring(input brf_in_t cmd_in);
        brf_out_t    res;
        int unsigned fill;
        int unsigned total;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        fill = held_bytes();
        res = '0;
        res.last = 1'b1;
        res.fill_level = 9'(fill);
        unique case (cmd_in.cmd)
            CMD_PUT: begin
                if (cmd_in.length <= 8 && RING_DEPTH - fill >= cmd_in.length) begin
                    for (i = 0; i < cmd_in.length; i++) begin
                        shadow_ring[shadow_wr_ptr[RING_AW-1:0]] = cmd_in.data[8*i +: 8];
                        shadow_wr_ptr = shadow_wr_ptr + 9'd1;
                    end
                    res.ok = 1'b1;
                    res.fill_level = 9'(held_bytes());
                end
                expected_results.push_back(res);
            end
            CMD_GET: begin
                if (cmd_in.length <= 8 && cmd_in.length <= fill) begin
                    res.ok = 1'b1;
                    res.read_bytes = pop_shadow(cmd_in.length);
                    res.byte_count = cmd_in.length;
                    res.fill_level = 9'(held_bytes());
                end
                expected_results.push_back(res);
            end
            CMD_DRAIN: begin
                drains_seen++;
                total = fill;
                k = 0;
                res.fill_level = '0;
                if (total == 0) begin
                    expected_results.push_back(res);
                end
                while (total > 0 && k < MAX_CHUNKS) begin
                    n = (total > 8) ? 8 : total;
                    res.ok = 1'b1;
                    res.read_bytes = pop_shadow(n);
                    res.byte_count = 4'(n);
                    total -= n;
                    res.last = (total == 0);
                    expected_results.push_back(res);
                    k++;
                end
            end
            default: begin
                expected_results.push_back(res);
            end
        endcase
        if (held_bytes() > peak_fill) begin
            peak_fill = held_bytes();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Queues one command and tracks the fill level so that runs can be shaped.
    task automatic add_cmd(input logic [1:0] cmd, input logic [63:0] data,
                           input int unsigned len);
        pending_t p;
        p.item.cmd = cmd;
        p.item.data = data;
        p.item.length = 4'(len);
        p.gap = send_calm ? 0 : $urandom_range(0, 4);
        pending_q.push_back(p);
        unique case (cmd)
            CMD_PUT: begin
                if (len <= 8 && RING_DEPTH - gen_fill >= len) gen_fill += len;
            end
            CMD_GET: begin
                if (len <= 8 && len <= gen_fill) gen_fill -= len;
            end
            CMD_DRAIN: begin
                gen_fill = 0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Driver: presents queued commands with a random gap after each transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_ring(s_data);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    next_cmd = pending_q.pop_front();
                    s_data <= next_cmd.item;
                    s_valid <= 1'b1;
                    gap_left <= next_cmd.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and stalls at random after it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 2;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", m_data.read_bytes, '0);
                end else begin
                    brf_out_t want;
                    want = expected_results.pop_front();
                    if (m_data.ok !== want.ok)
                        report_mismatch("ok", 64'(m_data.ok), 64'(want.ok));
                    if (m_data.read_bytes !== want.read_bytes)
                        report_mismatch("read_bytes", m_data.read_bytes, want.read_bytes);
                    if (m_data.byte_count !== want.byte_count)
                        report_mismatch("byte_count", 64'(m_data.byte_count),
                                        64'(want.byte_count));
                    if (m_data.fill_level !== want.fill_level)
                        report_mismatch("fill_level", 64'(m_data.fill_level),
                                        64'(want.fill_level));
                    if (m_data.last !== want.last)
                        report_mismatch("last", 64'(m_data.last), 64'(want.last));
                end
                results_checked++;
                if (results_checked % 40 == 0) begin
                    ready_calm = ($urandom_range(0, 2) == 0);
                end
                stall_draw = ready_calm ? 0 : $urandom_range(0, 4);
                if (stall_draw == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    stall_left <= stall_draw;
                end
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= (stall_left == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned made;
        int unsigned mode;
        int unsigned i;
        int unsigned len;
        int unsigned start_count;

        // Directed corner cases.
        add_cmd(CMD_GET, '0, 1);                    // get from an empty ring
        add_cmd(CMD_DRAIN, '0, 0);                  // drain of an empty ring
        add_cmd(CMD_PUT, rand_word(), 0);           // zero-length put
        add_cmd(CMD_GET, '0, 0);                    // zero-length get
        add_cmd(CMD_PUT, '1, 8);
        add_cmd(CMD_PUT, '0, 8);
        add_cmd(CMD_PUT, rand_word(), 15);          // length above eight
        add_cmd(CMD_GET, '1, 9);                    // length above eight
        add_cmd(CMD_UNKNOWN, '1, 15);
        add_cmd(CMD_GET, '0, 8);
        add_cmd(CMD_PUT, 64'h0000_0000_00ab_cdef, 3);
        add_cmd(CMD_GET, '0, 12);                   // too few held
        add_cmd(CMD_GET, '0, 4);
        add_cmd(CMD_DRAIN, '1, 15);                 // single short chunk
        add_cmd(CMD_PUT, rand_word(), 8);
        add_cmd(CMD_PUT, rand_word(), 8);
        add_cmd(CMD_PUT, rand_word(), 8);
        add_cmd(CMD_PUT, rand_word(), 5);
        add_cmd(CMD_DRAIN, '0, 0);                  // several chunks, short last
        add_cmd(CMD_DRAIN, '0, 0);

        // Random runs.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            send_calm = ($urandom_range(0, 3) == 0);
            start_count = pending_q.size();
            mode = (made == 0) ? 0 : $urandom_range(0, 9);
            unique case (mode)
                0, 1: begin
                    // Fill until full, land exactly on full, then overflow.
                    while (gen_fill < RING_DEPTH - 8) begin
                        add_cmd(CMD_PUT, rand_word(), $urandom_range(5, 8));
                    end
                    add_cmd(CMD_PUT, rand_word(), 8);
                    add_cmd(CMD_PUT, rand_word(), RING_DEPTH - gen_fill);
                    add_cmd(CMD_PUT, rand_word(), $urandom_range(1, 8));
                end
                2, 3: begin
                    for (i = 0; i < $urandom_range(6, 12); i++) begin
                        len = ($urandom_range(0, 5) == 0) ? gen_fill : $urandom_range(0, 8);
                        add_cmd(CMD_GET, rand_word(), (len > 8) ? $urandom_range(0, 8) : len);
                    end
                end
                4: begin
                    add_cmd(CMD_DRAIN, rand_word(), $urandom_range(0, 15));
                end
                8: begin
                    for (i = 0; i < 3; i++) begin
                        if ($urandom_range(0, 1) == 0)
                            add_cmd(CMD_UNKNOWN, rand_word(), $urandom_range(0, 15));
                        else
                            add_cmd(($urandom_range(0, 1) == 0) ? CMD_PUT : CMD_GET,
                                    rand_word(), $urandom_range(9, 15));
                    end
                end
                default: begin
                    for (i = 0; i < 10; i++) begin
                        add_cmd(($urandom_range(0, 2) == 0) ? CMD_GET : CMD_PUT,
                                rand_word(), $urandom_range(0, 8));
                    end
                end
            endcase
            made += pending_q.size() - start_count;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d commands including %0d drains, %0d results checked",
                 items_accepted, drains_seen, results_checked);
        $display("peak fill %0d of %0d bytes, %0d mismatches", peak_fill, RING_DEPTH,
                 error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_dpath.sv
rtl/brf_ctrl.sv
rtl/byte_ring_fifo_burst.sv
dv/byte_ring_fifo_burst_tb.sv
